// ----- rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// pip_pkg
// Shared constants and types for the point-in-polygon tester.
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    // Polygon capacity and derived widths
    localparam int MAX_VERTICES = 256;
    localparam int MIN_VERTICES = 3;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int N_W          = $clog2(MAX_VERTICES + 1);

    // Field widths
    localparam int COORD_W = 32;
    localparam int CNT_W   = 9;
    localparam int IDX_W   = 8;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;

    // Cycles from the last memory read to the final parity update
    localparam int PIPE_LAT = 3;
    localparam int DRAIN_W  = $clog2(PIPE_LAT);

    // Action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_vertex;

    localparam int VTX_W = $bits(t_vertex);

    typedef struct packed {
        logic vld;
        logic hit;
    } t_edge_res;

endpackage : pip_pkg

`default_nettype wire

// ----- rtl/pip_ram.sv -----
// ----------------------------------------------------------------------------
// pip_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : pip_ram

`default_nettype wire

// ----- rtl/pip_edge.sv -----
// ----------------------------------------------------------------------------
// pip_edge
// Two-stage edge crossing test: differences, then exact cross products.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    input  wire pip_pkg::t_vertex  i_cur,
    input  wire pip_pkg::t_vertex  i_prev,
    input  wire pip_pkg::t_coord   i_px,
    input  wire pip_pkg::t_coord   i_py,
    output pip_pkg::t_edge_res     o_res
);
    import pip_pkg::*;

    // stage 1: straddle flag and coordinate differences
    logic  r1_vld, r1_str;
    t_diff r1_dxp, r1_dy, r1_dxe, r1_dyp;
    // stage 2: cross products
    logic  r2_vld, r2_str, r2_dy_pos;
    t_prod r2_p1, r2_p2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_str <= (i_cur.y > i_py) != (i_prev.y > i_py);
        r1_dxp <= t_diff'(i_px) - t_diff'(i_cur.x);
        r1_dy  <= t_diff'(i_prev.y) - t_diff'(i_cur.y);
        r1_dxe <= t_diff'(i_prev.x) - t_diff'(i_cur.x);
        r1_dyp <= t_diff'(i_py) - t_diff'(i_cur.y);

        r2_str    <= r1_str;
        r2_dy_pos <= !r1_dy[DIFF_W-1];   // dy is nonzero whenever the edge straddles
        r2_p1     <= r1_dxp * r1_dy;
        r2_p2     <= r1_dxe * r1_dyp;
    end

    // crossing strictly right of the point, direction follows sign of dy
    always_comb begin
        o_res.vld = r2_vld;
        o_res.hit = r2_str & (r2_dy_pos ? (r2_p1 < r2_p2) : (r2_p2 < r2_p1));
    end

endmodule : pip_edge

`default_nettype wire

// ----- rtl/point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd crossing-number test against a polygon held in block RAM.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                               | Word
//  ---------+---------------------------------------+---------------------------
//  in       | i_in_valid / o_in_ready               | action, index, x, y
//  out      | o_out_valid / i_out_ready             | inside_res (queries only)
//  cfg      | i_cfg_we / i_cfg_wdata                | vertex_count
//
//  A load word is written to the vertex RAM at the edge it is accepted. A
//  query with n vertices in use issues n+1 RAM reads (the last vertex first,
//  then 0..n-1), one per cycle, bounded by the single RAM read port, then
//  drains the read/edge pipeline before it finishes. Fewer than three
//  vertices answer without reading the vertex RAM.
//  Reset is synchronous, active low; the vertex RAM is not cleared.
//  A finished result sits in the output register; a new word is taken while it
//  waits, and only a second finished query stalls until the first is taken.
//
`default_nettype none

module point_in_polygon_test (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input words
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic                    i_action,
    input  wire logic [pip_pkg::IDX_W-1:0] i_vertex_index,
    input  wire pip_pkg::t_coord         i_coord_x,
    input  wire pip_pkg::t_coord         i_coord_y,
    // result words
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic                         o_inside_res,
    // configuration
    input  wire logic                    i_cfg_we,
    input  wire logic [pip_pkg::CNT_W-1:0] i_cfg_wdata
);
    import pip_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_vcount;
    t_coord             r_px, r_py;
    logic [N_W-1:0]     r_n;          // clamped vertex count of this query
    logic [N_W-1:0]     r_rd_cnt;     // reads issued so far
    logic               r_rd_vld;     // RAM data valid this cycle
    logic               r_rd_first;   // that data is the closing vertex only
    t_vertex            r_prev;
    logic [DRAIN_W-1:0] r_drain;
    logic               r_parity;
    logic               r_out_vld, r_out_res;

    logic               in_acc, is_query, slot_ok, ram_we, out_free;
    logic [N_W-1:0]     n_cur, last_idx, cnt_m1;
    logic [ADDR_W-1:0]  raddr;
    t_vertex            wdata, rdata;
    t_edge_res          edge_res;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_vld;
    assign o_inside_res = r_out_res;

    assign in_acc   = i_in_valid & o_in_ready;
    assign is_query = (i_action == ACT_QUERY);
    assign slot_ok  = {24'd0, i_vertex_index} < 32'(MAX_VERTICES);
    assign ram_we   = in_acc & (i_action == ACT_LOAD) & slot_ok;
    assign out_free = !r_out_vld || i_out_ready;

    // counts above capacity act as full capacity
    assign n_cur = (32'(r_vcount) > 32'(MAX_VERTICES)) ? N_W'(MAX_VERTICES)
                                                       : N_W'(r_vcount);

    // read order: closing vertex n-1, then 0..n-1
    assign last_idx = r_n - N_W'(1);
    assign cnt_m1   = r_rd_cnt - N_W'(1);
    assign raddr    = (r_rd_cnt == '0) ? last_idx[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];

    assign wdata.x = i_coord_x;
    assign wdata.y = i_coord_y;

    // Loads and queries never overlap: a query is only taken in idle, after
    // every earlier load has been written.
    pip_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(i_vertex_index)),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_rd_vld & !r_rd_first),
        .i_cur   (rdata),
        .i_prev  (r_prev),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (edge_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && is_query) begin
                    n_state = (32'(n_cur) < 32'(MIN_VERTICES)) ? S_DONE : S_READ;
                end
            end
            S_READ: begin
                if (r_rd_cnt == r_n) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_drain == DRAIN_W'(PIPE_LAT - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vcount   <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_first <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= (r_state == S_READ);
            r_rd_first <= (r_state == S_READ) && (r_rd_cnt == '0);
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc && is_query) begin
            r_px     <= i_coord_x;
            r_py     <= i_coord_y;
            r_n      <= n_cur;
            r_rd_cnt <= '0;
            r_parity <= 1'b0;
        end else begin
            if (r_state == S_READ) begin
                r_rd_cnt <= r_rd_cnt + N_W'(1);
            end
            if (edge_res.vld && edge_res.hit) begin
                r_parity <= !r_parity;
            end
        end
        if (r_state == S_READ) begin
            r_drain <= '0;
        end else if (r_state == S_DRAIN) begin
            r_drain <= r_drain + DRAIN_W'(1);
        end
        if (r_rd_vld) begin
            r_prev <= rdata;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_res <= r_parity;
        end
    end

endmodule : point_in_polygon_test

`default_nettype wire

// ----- rtl/pip_checker.sv -----
// ----------------------------------------------------------------------------
// pip_checker
// Port-level checks on the point-in-polygon tester, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pip_checker (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      o_in_ready,
    input wire logic                      i_action,
    input wire logic                      o_out_valid,
    input wire logic                      i_out_ready,
    input wire logic                      o_inside_res
);
    import pip_pkg::*;

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_inside_res))
        else $error("result word dropped or changed while stalled");

    // ready is low after a query is taken
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_QUERY) |=> !o_in_ready)
        else $error("ready stayed high after a query");

    // a load completes in the cycle it is taken
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == ACT_LOAD) |=> o_in_ready)
        else $error("ready dropped after a load");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule : pip_checker

bind point_in_polygon_test pip_checker u_pip_checker (.*);

`default_nettype wire

// ----- test/tb_point_in_polygon_test.sv -----
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test
// Self-checking bench for the even-odd point-in-polygon tester. Polygons are
// loaded vertex by vertex, the vertex count is set while the block is idle,
// and query words are checked against a bit-exact crossing-number predictor
// with random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_point_in_polygon_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int     TOTAL_WORDS = 1850;
    localparam int     SETTLE      = PIPE_LAT + 8;   // loads have no result word
    localparam t_coord C_MIN       = 32'sh8000_0000;
    localparam t_coord C_MAX       = 32'sh7fff_ffff;

    // ------------------------------------------------------------------------
    // Polygon shadow and expected inside_res words
    // ------------------------------------------------------------------------
    class pip_scoreboard;
        t_coord           vx [MAX_VERTICES];
        t_coord           vy [MAX_VERTICES];
        logic [CNT_W-1:0] vertex_count;
        bit               inside_q [$];
        int unsigned      fails;

        function new();
            vertex_count = '0;
            fails        = 0;
            foreach (vx[i]) begin
                vx[i] = '0;
                vy[i] = '0;
            end
        endfunction

        function void set_count(logic [CNT_W-1:0] n);
            vertex_count = n;
        endfunction

        // Crossing parity of the ray from (px,py) toward +x. The crossing
        // abscissa is compared by cross-multiplying at full width, with the
        // comparison flipped when the edge runs downward.
        function bit crossing_parity(t_coord px, t_coord py);
            int unsigned        n;
            int unsigned        prev;
            bit                 parity;
            logic signed [33:0] dy;
            logic signed [33:0] dxp;
            logic signed [33:0] dxe;
            logic signed [33:0] dyp;
            logic signed [67:0] lhs;
            logic signed [67:0] rhs;
            // counts above capacity clamp to capacity
            n      = (vertex_count > MAX_VERTICES) ? MAX_VERTICES : vertex_count;
            parity = 1'b0;
            if (n < MIN_VERTICES)
                return 1'b0;
            prev = n - 1;                // closing edge first
            for (int unsigned i = 0; i < n; i++) begin
                if ((vy[i] > py) != (vy[prev] > py)) begin
                    dy  = vy[prev] - vy[i];
                    dxp = px - vx[i];
                    dxe = vx[prev] - vx[i];
                    dyp = py - vy[i];
                    lhs = dxp * dy;
                    rhs = dxe * dyp;
                    if ((dy > 0) ? (lhs < rhs) : (rhs < lhs))
                        parity = ~parity;
                end
                prev = i;
            end
            return parity;
        endfunction

        function void note_word(logic act, logic [IDX_W-1:0] idx, t_coord x, t_coord y);
            if (act == ACT_LOAD) begin
                vx[idx] = x;
                vy[idx] = y;
            end else begin
                inside_q.push_back(crossing_parity(x, y));
            end
        endfunction

        function void flag(string what, bit exp_v, bit got_v);
            fails++;
            if (fails <= 10)
                $display("%0t: %s: expected inside_res=%0b, got %0b",
                         $realtime, what, exp_v, got_v);
        endfunction

        function void check_inside(bit got);
            bit exp_v;
            if (inside_q.size() == 0) begin
                flag("result word with nothing pending", 1'b0, got);
            end else begin
                exp_v = inside_q.pop_front();
                if (exp_v != got)
                    flag("inside_res mismatch", exp_v, got);
            end
        endfunction

        function int unsigned pending();
            return inside_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT ports
    // ------------------------------------------------------------------------
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic               i_action       = ACT_LOAD;
    logic [IDX_W-1:0]   i_vertex_index = '0;
    t_coord             i_coord_x      = '0;
    t_coord             i_coord_y      = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic               o_inside_res;
    logic               i_cfg_we       = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata    = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    point_in_polygon_test dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_vertex_index (i_vertex_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_inside_res   (o_inside_res),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    pip_scoreboard sb;
    int unsigned   words_sent = 0;
    int unsigned   burst_left = 0;

    // ------------------------------------------------------------------------
    // Result side: stall pattern changes mode after a random run length, counted in cycles
    // ------------------------------------------------------------------------
    typedef enum int unsigned {RX_FREE, RX_COIN, RX_SPARSE, RX_MASK} t_rx_mode;

    t_rx_mode    rx_mode  = RX_FREE;
    int unsigned rx_left  = 0;
    int unsigned rx_tick  = 0;
    logic [7:0]  rx_mask  = '0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 300);
            rx_mask = 8'($urandom_range(0, 255));
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_FREE:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 7) == 0);
            default:   i_out_ready <= rx_mask[rx_tick % 8];
        endcase
    end

    // Result words are checked at the edge they are taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_inside(o_inside_res);
    end

    // ------------------------------------------------------------------------
    // Input side. All tasks start and end at a falling edge.
    // ------------------------------------------------------------------------

    // One word on the input channel. Words go out in bursts; within a burst
    // valid stays high from one word to the next.
    task automatic send_word(logic act, logic [IDX_W-1:0] idx, t_coord x, t_coord y);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid     = 1'b1;
        i_action       = act;
        i_vertex_index = idx;
        i_coord_x      = x;
        i_coord_y      = y;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_word(act, idx, x, y);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_vertex(int unsigned slot, t_coord x, t_coord y);
        send_word(ACT_LOAD, slot[IDX_W-1:0], x, y);
    endtask

    // index is a don't-care on queries, so it is kept random
    task automatic ask_inside(t_coord x, t_coord y);
        send_word(ACT_QUERY, IDX_W'($urandom_range(0, 255)), x, y);
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic wait_idle();
        int unsigned guard;
        i_in_valid = 1'b0;
        guard      = 0;
        while (sb.pending() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_vertex_count(logic [CNT_W-1:0] n);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = n;
        @(posedge i_clk);
        sb.set_count(n);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Coordinate at a given spread: about +-8.0, about +-4096.0, any value,
    // or mostly one of the corner values of the Q24.8 range.
    function automatic t_coord rand_coord(int unsigned spread);
        case (spread)
            0: return $signed($urandom_range(0, 4000)) - 2000;
            1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 5))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return 0;
                    3: return -1;
                    4: return 1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Query point: random at the polygon's spread, on a vertex, on the
    // horizontal or vertical line through a vertex, or a corner value.
    task automatic ask_near(int unsigned spread, int unsigned n_used);
        int unsigned v;
        int unsigned r;
        v = (n_used == 0) ? 0 : $urandom_range(0, n_used - 1);
        r = $urandom_range(0, 99);
        if (r < 55)
            ask_inside(rand_coord(spread), rand_coord(spread));
        else if (r < 70)
            ask_inside(sb.vx[v], sb.vy[v]);
        else if (r < 85)
            ask_inside(rand_coord(spread), sb.vy[v]);
        else if (r < 92)
            ask_inside(sb.vx[v], rand_coord(spread));
        else
            ask_inside(rand_coord(3), rand_coord(3));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned      phase;
        int unsigned      pick;
        int unsigned      spread;
        int unsigned      n_used;
        int unsigned      n_q;
        int unsigned      slot;
        bit               rev;
        logic [CNT_W-1:0] n_cfg;

        sb = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed -------------------------------------------------------
        // empty polygon answers outside
        write_vertex_count(0);
        ask_inside(0, 0);

        // unit square at +-1.0
        put_vertex(0, -256, -256);
        put_vertex(1,  256, -256);
        put_vertex(2,  256,  256);
        put_vertex(3, -256,  256);

        // one and two vertices: still outside
        write_vertex_count(1);
        ask_inside(0, 0);
        write_vertex_count(2);
        ask_inside(0, 0);

        // triangle, one point each side of the diagonal
        write_vertex_count(3);
        ask_inside(128, -128);
        ask_inside(-128, 128);

        // square: interior, points on edges and vertices, far outside
        write_vertex_count(4);
        ask_inside(0, 0);
        ask_inside(256, 0);
        ask_inside(-256, 0);
        ask_inside(256, 256);
        ask_inside(-256, -256);
        ask_inside(0, 256);
        ask_inside(C_MAX, 0);
        ask_inside(C_MIN, 0);
        ask_inside(0, C_MIN);

        // top slot, then a triangle spanning the full coordinate range
        put_vertex(255, C_MIN, C_MAX);
        put_vertex(0, C_MIN, C_MIN);
        put_vertex(1, C_MAX, C_MIN);
        put_vertex(2, 0, C_MAX);
        write_vertex_count(3);
        ask_inside(0, 0);
        ask_inside(C_MIN, C_MAX);
        ask_inside(C_MAX, C_MIN);

        // --- random polygons ------------------------------------------------
        // Each phase loads slots 0..n-1 (so every slot a query reads has been
        // written), adds a few stray loads, sets the count, then queries.
        // Phase 0 fills the whole store and runs with counts past capacity.
        for (phase = 0; words_sent < TOTAL_WORDS; phase++) begin
            pick   = $urandom_range(0, 99);
            spread = $urandom_range(0, 9);
            spread = (spread < 4) ? 0 : (spread < 7) ? 1 : (spread < 9) ? 2 : 3;
            if (phase == 0)
                n_cfg = 511;
            else if (pick < 2)
                n_cfg = CNT_W'($urandom_range(256, 511));
            else if (pick < 10)
                n_cfg = CNT_W'($urandom_range(0, 2));
            else if (pick < 30)
                n_cfg = CNT_W'($urandom_range(3, 40));
            else
                n_cfg = CNT_W'($urandom_range(3, 8));
            if (n_cfg > MAX_VERTICES && spread == 0)
                spread = 1;
            n_used = (n_cfg > MAX_VERTICES) ? MAX_VERTICES : n_cfg;

            rev = ($urandom_range(0, 3) == 0);
            for (int unsigned k = 0; k < n_used; k++) begin
                slot = rev ? (n_used - 1 - k) : k;
                put_vertex(slot, rand_coord(spread), rand_coord(spread));
            end
            // stray loads anywhere in the store
            repeat ($urandom_range(0, 2))
                put_vertex($urandom_range(0, 255), rand_coord(spread), rand_coord(spread));

            write_vertex_count(n_cfg);
            n_q = (n_cfg > MAX_VERTICES) ? $urandom_range(2, 4) : $urandom_range(4, 24);
            repeat (n_q) begin
                // now and then move a vertex between queries
                if (n_used != 0 && $urandom_range(0, 9) == 0)
                    put_vertex($urandom_range(0, n_used - 1),
                               rand_coord(spread), rand_coord(spread));
                ask_near(spread, n_used);
            end

            // past capacity, then exactly at capacity
            if (n_cfg > MAX_VERTICES) begin
                write_vertex_count(MAX_VERTICES);
                repeat ($urandom_range(2, 4))
                    ask_near(spread, n_used);
            end
        end

        // --- wind down ------------------------------------------------------
        wait_idle();
        if (sb.pending() != 0)
            sb.flag("result word never arrived", 1'b0, 1'b0);
        if (sb.fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hang guard, well above the slowest legal run
    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
